>>> rtl/fpv_pkg.sv
// shared types and constants of the fixed-point vec3 alu
// opcodes, job descriptor passed through the queue, back-end states
// no dependencies
package fpv_pkg;

  localparam int FRAC_BITS = 32;
  localparam int WORD_W    = 64;
  localparam int QDEPTH    = 2;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int QCW       = $clog2(QDEPTH + 1);
  localparam int DIV_W     = WORD_W + FRAC_BITS;
  localparam int DIV_CW    = $clog2(DIV_W);
  localparam int SQ_STEPS  = WORD_W;
  localparam int SQ_CW     = $clog2(SQ_STEPS);
  localparam int SQ_REMW   = WORD_W + 3;

  localparam logic [WORD_W-1:0] FX_ONE = WORD_W'(1) << FRAC_BITS;
  localparam logic [WORD_W-1:0] FX_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] FX_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [2:0][WORD_W-1:0] vec_t;

  typedef enum logic [4:0] {
    OP_ADD       = 5'd0,
    OP_SUB       = 5'd1,
    OP_NEG       = 5'd2,
    OP_ABS       = 5'd3,
    OP_SCALE     = 5'd4,
    OP_MULS      = 5'd5,
    OP_DIVS      = 5'd6,
    OP_ADDS      = 5'd7,
    OP_SUBS      = 5'd8,
    OP_DOT       = 5'd9,
    OP_CROSS     = 5'd10,
    OP_LERP_CLMP = 5'd11,
    OP_LERP      = 5'd12,
    OP_MAG       = 5'd13,
    OP_SQMAG     = 5'd14,
    OP_DIST      = 5'd15,
    OP_NORM      = 5'd16,
    OP_EQUAL     = 5'd17,
    OP_XZ_DOT    = 5'd18,
    OP_XZ_CROSS  = 5'd19,
    OP_XZ_MAG    = 5'd20,
    OP_XZ_SQMAG  = 5'd21,
    OP_XZ_DIST   = 5'd22,
    OP_XZ_SQDIST = 5'd23
  } op_t;

  // how the back end folds the products into the result
  typedef enum logic [2:0] {
    CMB_NONE,
    CMB_VEC,
    CMB_LERP,
    CMB_CROSS,
    CMB_DOT,
    CMB_XCROSS
  } cmb_t;

  typedef struct packed {
    cmb_t  cmb;
    logic  two_pass;
    logic  do_sqrt;
    logic  do_div;
    logic  div_by_root;
    vec_t  x1;
    vec_t  y1;
    vec_t  x2;
    vec_t  y2;
    vec_t  pre;
    word_t dvs;
    logic  eq;
    logic  err;
  } job_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_MUL,
    BS_COMB,
    BS_SQRT,
    BS_SQEND,
    BS_DIV,
    BS_DONE
  } bst_t;

endpackage

>>> rtl/fixed_point_vec3_alu_unit.sv
// Fixed-point 3D vector unit: one result word per input word, in order.
// A simple operation (add, sub, negate, abs, scalar add/sub, equal) skips the
// multiply lanes in the back end; products take one pass of the three shared
// multiply lanes (cross products use two passes), a square root computes one
// bit per cycle and a divide computes 64 + FRAC_BITS quotient bits, one per
// cycle. The front end takes a new word every cycle while the 2-entry job
// queue has room, so input and output stall independently.
module fixed_point_vec3_alu_unit import fpv_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [447:0] in_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
  input  logic [4:0]   in_tuser,   // opcode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [263:0] out_tdata   // r_x, r_y, r_z, scalar_out, equal_flag,
                                   // divide_error, zero fill
);

  job_t  front_job;
  job_t  q_head;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  logic  push;
  vec_t  a;
  vec_t  b;

  assign a = {in_tdata[191:128], in_tdata[127:64], in_tdata[63:0]};
  assign b = {in_tdata[383:320], in_tdata[319:256], in_tdata[255:192]};

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  fpv_front u_front (
    .opcode (in_tuser),
    .a      (a),
    .b      (b),
    .s      (in_tdata[447:384]),
    .job    (front_job)
  );

  fpv_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (front_job),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .head  (q_head)
  );

  fpv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> rtl/fpv_front.sv
// front end: decodes the opcode and prepares operands for the back end
// simple operations are finished here; depends on fpv_pkg
module fpv_front import fpv_pkg::*; (
  input  logic [4:0]   opcode,
  input  vec_t         a,
  input  vec_t         b,
  input  word_t        s,
  output job_t         job
);

  vec_t  d;
  vec_t  bma;
  vec_t  abs_a;
  word_t t;
  op_t   op;

  assign op = op_t'(opcode);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i]     = a[i] - b[i];
      bma[i]   = b[i] - a[i];
      abs_a[i] = a[i][WORD_W-1] ? (WORD_W'(0) - a[i]) : a[i];
    end
  end

  // lerp fraction clamped to [0, 1] for the clamped lerp only
  always_comb begin
    if (op == OP_LERP_CLMP && s[WORD_W-1]) begin
      t = '0;
    end else if (op == OP_LERP_CLMP && s > FX_ONE) begin
      t = FX_ONE;
    end else begin
      t = s;
    end
  end

  always_comb begin
    job     = '0;
    job.cmb = CMB_NONE;
    job.eq  = (a == b);
    unique case (op) inside
      OP_ADD: begin
        for (int i = 0; i < 3; i++) job.pre[i] = a[i] + b[i];
      end
      OP_SUB: job.pre = d;
      OP_NEG: begin
        for (int i = 0; i < 3; i++) job.pre[i] = WORD_W'(0) - a[i];
      end
      OP_ABS: job.pre = abs_a;
      OP_SCALE: begin
        job.cmb = CMB_VEC;
        job.x1  = a;
        job.y1  = b;
      end
      OP_MULS: begin
        job.cmb = CMB_VEC;
        job.x1  = a;
        job.y1  = {s, s, s};
      end
      OP_DIVS: begin
        job.do_div = 1'b1;
        job.pre    = a;
        job.dvs    = s;
        job.err    = (s == '0);
      end
      OP_ADDS: begin
        for (int i = 0; i < 3; i++) job.pre[i] = a[i] + s;
      end
      OP_SUBS: begin
        for (int i = 0; i < 3; i++) job.pre[i] = a[i] - s;
      end
      OP_DOT: begin
        job.cmb = CMB_DOT;
        job.x1  = a;
        job.y1  = b;
      end
      OP_CROSS: begin
        job.cmb      = CMB_CROSS;
        job.two_pass = 1'b1;
        job.x1       = {a[0], a[2], a[1]};
        job.y1       = {b[1], b[0], b[2]};
        job.x2       = {a[1], a[0], a[2]};
        job.y2       = {b[0], b[2], b[1]};
      end
      OP_LERP_CLMP, OP_LERP: begin
        job.cmb = CMB_LERP;
        job.x1  = bma;
        job.y1  = {t, t, t};
        job.pre = a;
      end
      OP_MAG, OP_SQMAG: begin
        job.cmb     = CMB_DOT;
        job.x1      = a;
        job.y1      = a;
        job.do_sqrt = (op == OP_MAG);
      end
      OP_DIST: begin
        job.cmb     = CMB_DOT;
        job.x1      = d;
        job.y1      = d;
        job.do_sqrt = 1'b1;
      end
      OP_NORM: begin
        job.cmb         = CMB_DOT;
        job.x1          = a;
        job.y1          = a;
        job.do_sqrt     = 1'b1;
        job.do_div      = 1'b1;
        job.div_by_root = 1'b1;
        job.pre         = a;
      end
      OP_XZ_DOT: begin
        job.cmb   = CMB_DOT;
        job.x1    = a;
        job.x1[1] = '0;
        job.y1    = b;
      end
      OP_XZ_CROSS: begin
        job.cmb      = CMB_XCROSS;
        job.two_pass = 1'b1;
        job.x1[0]    = a[0];
        job.y1[0]    = b[2];
        job.x2[0]    = a[2];
        job.y2[0]    = b[0];
      end
      OP_XZ_MAG, OP_XZ_SQMAG: begin
        job.cmb     = CMB_DOT;
        job.x1      = a;
        job.x1[1]   = '0;
        job.y1      = a;
        job.do_sqrt = (op == OP_XZ_MAG);
      end
      OP_XZ_DIST, OP_XZ_SQDIST: begin
        job.cmb     = CMB_DOT;
        job.x1      = d;
        job.x1[1]   = '0;
        job.y1      = d;
        job.do_sqrt = (op == OP_XZ_DIST);
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/fpv_queue.sv
// short job queue between front and back end
// depends on fpv_pkg for the job descriptor
module fpv_queue import fpv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t head
);

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r;
  logic [QAW-1:0] rptr_r;
  logic [QCW-1:0] cnt_r;

  assign full  = (cnt_r == QCW'(QDEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + QAW'(1);
      if (pop)  rptr_r <= rptr_r + QAW'(1);
      if (push && !pop) begin
        cnt_r <= cnt_r + QCW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCW'(1);
      end
    end
  end

endmodule

>>> rtl/fpv_div.sv
// one lane of signed fixed-point division, one quotient bit per cycle
// saturates on overflow and on a zero divisor (a zero numerator then gives zero); depends on fpv_pkg
module fpv_div import fpv_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t num,
  input  word_t den,
  output logic  busy,
  output word_t quo
);

  logic              busy_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_W-1:0]  nrm_r;
  logic [DIV_W-1:0]  q_r;
  word_t             rem_r;
  word_t             den_r;
  logic              neg_r;
  logic              dz_r;
  logic              nz_r;
  logic              nneg_r;

  word_t             an;
  word_t             ad;
  logic [WORD_W:0]   remsh;
  logic              ge;
  logic              over_pos;
  logic              over_neg;

  assign an    = num[WORD_W-1] ? (WORD_W'(0) - num) : num;
  assign ad    = den[WORD_W-1] ? (WORD_W'(0) - den) : den;
  assign remsh = {rem_r, nrm_r[DIV_W-1]};
  assign ge    = (remsh >= {1'b0, den_r});
  assign busy  = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= (ad != '0);
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + DIV_CW'(1);
      if (cnt_r == DIV_CW'(DIV_W - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nrm_r  <= {an, {FRAC_BITS{1'b0}}};
      q_r    <= '0;
      rem_r  <= '0;
      den_r  <= ad;
      neg_r  <= num[WORD_W-1] ^ den[WORD_W-1];
      dz_r   <= (ad == '0);
      nz_r   <= (num != '0);
      nneg_r <= num[WORD_W-1];
    end else if (busy_r) begin
      nrm_r <= {nrm_r[DIV_W-2:0], 1'b0};
      q_r   <= {q_r[DIV_W-2:0], ge};
      rem_r <= ge ? WORD_W'(remsh - {1'b0, den_r}) : remsh[WORD_W-1:0];
    end
  end

  assign over_pos = (|q_r[DIV_W-1:WORD_W-1]);
  assign over_neg = (|q_r[DIV_W-1:WORD_W]) || (q_r[WORD_W-1] && (|q_r[WORD_W-2:0]));

  always_comb begin
    if (dz_r) begin
      quo = !nz_r ? '0 : (nneg_r ? FX_MIN : FX_MAX);
    end else if (neg_r) begin
      quo = over_neg ? FX_MIN : (WORD_W'(0) - q_r[WORD_W-1:0]);
    end else begin
      quo = over_pos ? FX_MAX : q_r[WORD_W-1:0];
    end
  end

endmodule

>>> rtl/fpv_back.sv
// back end: sequencer with three multiply lanes, a square-root unit,
// three divider lanes and the output register; depends on fpv_pkg, fpv_div
module fpv_back import fpv_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  job_t         q_head,
  output logic         q_pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [263:0] out_tdata
);

  bst_t                    state_r;
  bst_t                    state_nxt;
  job_t                    job_r;
  logic [1:0]              cnt_r;
  logic                    pass_r;
  logic [2:0][127:0]       acc_r;
  logic [2:0][127:0]       acc_nxt;
  vec_t                    p_r;
  vec_t                    q_r;
  vec_t                    r_r;
  word_t                   sc_r;
  logic [2*WORD_W-1:0]     rad_r;
  logic [SQ_REMW-1:0]      rem_r;
  word_t                   root_r;
  logic [SQ_CW-1:0]        scnt_r;

  logic                    out_valid_r;
  vec_t                    out_r_r;
  word_t                   out_sc_r;
  logic                    out_eq_r;
  logic                    out_err_r;

  logic                    out_free;
  logic                    load;
  logic                    out_ld;
  logic                    div_start;
  logic [2:0]              div_busy;
  vec_t                    quo;
  word_t                   div_den;
  vec_t                    prod;
  vec_t                    xs_sel;
  vec_t                    ys_sel;
  word_t                   dot_sum;
  logic [SQ_REMW-1:0]      sq_rem;
  logic [SQ_REMW-1:0]      sq_trial;
  logic                    sq_ge;

  assign out_free = !out_valid_r || out_tready;

  // multiply lanes: one signed 33x33 partial product per cycle each
  assign xs_sel = pass_r ? job_r.x2 : job_r.x1;
  assign ys_sel = pass_r ? job_r.y2 : job_r.y1;

  always_comb begin
    logic signed [32:0]  xs;
    logic signed [32:0]  ys;
    logic signed [65:0]  pp;
    logic [127:0]        ppw;
    for (int i = 0; i < 3; i++) begin
      xs  = cnt_r[0] ? $signed({xs_sel[i][63], xs_sel[i][63:32]})
                     : $signed({1'b0, xs_sel[i][31:0]});
      ys  = cnt_r[1] ? $signed({ys_sel[i][63], ys_sel[i][63:32]})
                     : $signed({1'b0, ys_sel[i][31:0]});
      pp  = xs * ys;
      ppw = {{62{pp[65]}}, pp};
      case (cnt_r)
        2'd0:    ppw = ppw;
        2'd3:    ppw = ppw << 64;
        default: ppw = ppw << 32;
      endcase
      acc_nxt[i] = (cnt_r == 2'd0) ? ppw : (acc_r[i] + ppw);
      prod[i]    = acc_nxt[i][FRAC_BITS+WORD_W-1:FRAC_BITS];
    end
  end

  assign dot_sum = p_r[0] + p_r[1] + p_r[2];

  // square root: two radicand bits per cycle
  assign sq_rem   = {rem_r[SQ_REMW-3:0], rad_r[2*WORD_W-1:2*WORD_W-2]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_ge    = (sq_rem >= sq_trial);

  assign div_den = job_r.div_by_root ? root_r : job_r.dvs;

  for (genvar g = 0; g < 3; g++) begin : g_div
    fpv_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (div_start),
      .num   (job_r.pre[g]),
      .den   (div_den),
      .busy  (div_busy[g]),
      .quo   (quo[g])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE: begin
        if (q_valid) state_nxt = (q_head.cmb != CMB_NONE) ? BS_MUL : BS_COMB;
      end
      BS_MUL: begin
        if (cnt_r == 2'd3 && (pass_r || !job_r.two_pass)) state_nxt = BS_COMB;
      end
      BS_COMB: begin
        if (job_r.do_sqrt) begin
          state_nxt = BS_SQRT;
        end else if (job_r.do_div) begin
          state_nxt = BS_DIV;
        end else begin
          state_nxt = BS_DONE;
        end
      end
      BS_SQRT: begin
        if (scnt_r == SQ_CW'(SQ_STEPS - 1)) state_nxt = BS_SQEND;
      end
      BS_SQEND: begin
        state_nxt = (job_r.do_div && root_r != '0) ? BS_DIV : BS_DONE;
      end
      BS_DIV: begin
        if (!div_busy[0]) state_nxt = BS_DONE;
      end
      BS_DONE: begin
        if (out_free) begin
          if (q_valid) begin
            state_nxt = (q_head.cmb != CMB_NONE) ? BS_MUL : BS_COMB;
          end else begin
            state_nxt = BS_IDLE;
          end
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    load      = 1'b0;
    out_ld    = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      BS_IDLE:  load = q_valid;
      BS_COMB:  div_start = !job_r.do_sqrt && job_r.do_div;
      BS_SQEND: div_start = job_r.do_div && (root_r != '0);
      BS_DONE: begin
        out_ld = out_free;
        load   = out_free && q_valid;
      end
      default: ;
    endcase
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      cnt_r       <= '0;
      pass_r      <= 1'b0;
      scnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        cnt_r  <= '0;
        pass_r <= 1'b0;
      end else if (state_r == BS_MUL) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3 && job_r.two_pass) pass_r <= 1'b1;
      end
      if (state_r == BS_COMB) begin
        scnt_r <= '0;
      end else if (state_r == BS_SQRT) begin
        scnt_r <= scnt_r + SQ_CW'(1);
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= q_head;
      r_r   <= q_head.pre;
      sc_r  <= '0;
    end
    unique case (state_r)
      BS_MUL: begin
        acc_r <= acc_nxt;
        if (cnt_r == 2'd3) begin
          if (!pass_r) begin
            p_r <= prod;
          end else begin
            q_r <= prod;
          end
        end
      end
      BS_COMB: begin
        case (job_r.cmb)
          CMB_VEC:  r_r <= p_r;
          CMB_LERP: begin
            for (int i = 0; i < 3; i++) r_r[i] <= job_r.pre[i] + p_r[i];
          end
          CMB_CROSS: begin
            for (int i = 0; i < 3; i++) r_r[i] <= p_r[i] - q_r[i];
          end
          CMB_DOT:    sc_r <= dot_sum;
          CMB_XCROSS: sc_r <= p_r[0] - q_r[0];
          default: ;
        endcase
        // a negative wrapped sum has a root of zero
        rad_r  <= dot_sum[WORD_W-1] ? '0 : ({{WORD_W{1'b0}}, dot_sum} << FRAC_BITS);
        rem_r  <= '0;
        root_r <= '0;
      end
      BS_SQRT: begin
        rad_r  <= {rad_r[2*WORD_W-3:0], 2'b00};
        rem_r  <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
        root_r <= {root_r[WORD_W-2:0], sq_ge};
      end
      BS_SQEND: begin
        // normalize returns only the vector, its scalar stays zero
        sc_r <= job_r.div_by_root ? '0 : root_r;
        if (job_r.do_div) r_r <= '0;
      end
      BS_DIV: begin
        if (!div_busy[0]) r_r <= quo;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_r_r   <= r_r;
      out_sc_r  <= sc_r;
      out_eq_r  <= job_r.eq;
      out_err_r <= job_r.err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_err_r, out_eq_r, out_sc_r, out_r_r[2], out_r_r[1], out_r_r[0]};

`ifndef NO_ASSERTIONS
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("job popped from empty queue");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy[0]) else $error("divider restarted while busy");

  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_DIV && div_busy[0]) |=> state_r == BS_DIV)
    else $error("left divide state before quotient was ready");

  a_mul_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_MUL && cnt_r != 2'd3) |=> state_r == BS_MUL)
    else $error("multiply pass cut short");
`endif

endmodule

>>> dv/fpv_checker.sv
// watches both streams of the fixed-point vec3 alu, predicts each result word
// and compares it field by field; depends on fpv_pkg for opcodes and widths
`timescale 1ns / 1ps
module fpv_checker import fpv_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [447:0] in_tdata,
  input  logic [4:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [263:0] out_tdata,
  output int           fail_count,
  output int           pending
);

  typedef struct {
    word_t r [3];
    word_t sc;
    logic  eq;
    logic  err;
  } alu_result_t;

  alu_result_t result_q [$];

  // full signed product, floor shift by the fraction width, wrapped to 64 bits
  function automatic word_t fx_mul(word_t x, word_t y);
    logic signed [127:0] xs, ys, p;
    xs = $signed(x);
    ys = $signed(y);
    p = xs * ys;
    return p[FRAC_BITS +: WORD_W];
  endfunction

  // truncating divide with saturation; zero divisor saturates by sign of n, or gives zero for zero n
  function automatic word_t fx_div(word_t n, word_t d);
    logic        neg;
    word_t       an, ad;
    logic [127:0] num, q;
    neg = n[63] ^ d[63];
    an = n[63] ? -n : n;
    ad = d[63] ? -d : d;
    if (ad == 0) begin
      if (n == 0) return '0;
      return n[63] ? FX_MIN : FX_MAX;
    end
    num = {64'b0, an} << FRAC_BITS;
    q = num / {64'b0, ad};
    if (neg) return (q > {64'b0, FX_MIN}) ? FX_MIN : -q[63:0];
    return (q > {64'b0, FX_MAX}) ? FX_MAX : q[63:0];
  endfunction

  // floor of sqrt(v << FRAC_BITS); negative operand gives zero
  function automatic word_t fx_sqrt(word_t v);
    logic [127:0] target, c;
    word_t r;
    if (v[63]) return '0;
    target = {64'b0, v} << FRAC_BITS;
    r = '0;
    for (int b = 62; b >= 0; b--) begin
      c = {64'b0, r | (word_t'(1) << b)};
      if (c * c <= target) r = c[63:0];
    end
    return r;
  endfunction

  function automatic alu_result_t vec3_alu_result(op_t op, word_t a [3], word_t b [3],
                                                  word_t s);
    alu_result_t res;
    word_t t, d0, d1, d2;
    res.r = '{default: '0};
    res.sc = '0;
    res.err = 1'b0;
    res.eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
    case (op)
      OP_ADD:   for (int i = 0; i < 3; i++) res.r[i] = a[i] + b[i];
      OP_SUB:   for (int i = 0; i < 3; i++) res.r[i] = a[i] - b[i];
      OP_NEG:   for (int i = 0; i < 3; i++) res.r[i] = -a[i];
      OP_ABS:   for (int i = 0; i < 3; i++) res.r[i] = a[i][63] ? -a[i] : a[i];
      OP_SCALE: for (int i = 0; i < 3; i++) res.r[i] = fx_mul(a[i], b[i]);
      OP_MULS:  for (int i = 0; i < 3; i++) res.r[i] = fx_mul(a[i], s);
      OP_DIVS: begin
        for (int i = 0; i < 3; i++) res.r[i] = fx_div(a[i], s);
        res.err = (s == 0);
      end
      OP_ADDS:  for (int i = 0; i < 3; i++) res.r[i] = a[i] + s;
      OP_SUBS:  for (int i = 0; i < 3; i++) res.r[i] = a[i] - s;
      OP_DOT:   res.sc = fx_mul(a[0], b[0]) + fx_mul(a[1], b[1]) + fx_mul(a[2], b[2]);
      OP_CROSS: begin
        res.r[0] = fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]);
        res.r[1] = fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]);
        res.r[2] = fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]);
      end
      OP_LERP_CLMP, OP_LERP: begin
        t = s;
        if (op == OP_LERP_CLMP) begin
          if (t[63]) t = '0;
          else if (t > FX_ONE) t = FX_ONE;
        end
        for (int i = 0; i < 3; i++) res.r[i] = a[i] + fx_mul(b[i] - a[i], t);
      end
      OP_MAG, OP_SQMAG: begin
        res.sc = fx_mul(a[0], a[0]) + fx_mul(a[1], a[1]) + fx_mul(a[2], a[2]);
        if (op == OP_MAG) res.sc = fx_sqrt(res.sc);
      end
      OP_DIST: begin
        d0 = a[0] - b[0];
        d1 = a[1] - b[1];
        d2 = a[2] - b[2];
        res.sc = fx_sqrt(fx_mul(d0, d0) + fx_mul(d1, d1) + fx_mul(d2, d2));
      end
      OP_NORM: begin
        t = fx_sqrt(fx_mul(a[0], a[0]) + fx_mul(a[1], a[1]) + fx_mul(a[2], a[2]));
        if (t != 0)
          for (int i = 0; i < 3; i++) res.r[i] = fx_div(a[i], t);
      end
      OP_XZ_DOT:   res.sc = fx_mul(a[0], b[0]) + fx_mul(a[2], b[2]);
      OP_XZ_CROSS: res.sc = fx_mul(a[0], b[2]) - fx_mul(a[2], b[0]);
      OP_XZ_MAG, OP_XZ_SQMAG: begin
        res.sc = fx_mul(a[0], a[0]) + fx_mul(a[2], a[2]);
        if (op == OP_XZ_MAG) res.sc = fx_sqrt(res.sc);
      end
      OP_XZ_DIST, OP_XZ_SQDIST: begin
        d0 = a[0] - b[0];
        d2 = a[2] - b[2];
        res.sc = fx_mul(d0, d0) + fx_mul(d2, d2);
        if (op == OP_XZ_DIST) res.sc = fx_sqrt(res.sc);
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(string name, word_t want, word_t got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  initial fail_count = 0;
  assign pending = result_q.size();

  always @(posedge clk) begin
    word_t a [3], b [3];
    alu_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        for (int i = 0; i < 3; i++) begin
          a[i] = in_tdata[64*i +: 64];
          b[i] = in_tdata[64*(i+3) +: 64];
        end
        result_q.push_back(vec3_alu_result(op_t'(in_tuser), a, b, in_tdata[384 +: 64]));
      end
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $error("result word with none outstanding: %h", out_tdata);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          check_field("r_x", want.r[0], out_tdata[0 +: 64]);
          check_field("r_y", want.r[1], out_tdata[64 +: 64]);
          check_field("r_z", want.r[2], out_tdata[128 +: 64]);
          check_field("scalar_out", want.sc, out_tdata[192 +: 64]);
          check_field("equal_flag", word_t'(want.eq), word_t'(out_tdata[256]));
          check_field("divide_error", word_t'(want.err), word_t'(out_tdata[257]));
        end
      end
    end
  end

endmodule

>>> dv/tb_fixed_point_vec3_alu_unit.sv
// top of the fixed-point vec3 alu bench: clock, reset, word stimulus, verdict
// depends on fpv_pkg, fixed_point_vec3_alu_unit and fpv_checker
`timescale 1ns / 1ps
module tb_fixed_point_vec3_alu_unit;
  import fpv_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [447:0] in_tdata;    // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
  logic [4:0]   in_tuser;    // opcode
  logic         out_tvalid;
  logic         out_tready;
  logic [263:0] out_tdata;   // r_x, r_y, r_z, scalar_out, equal_flag, divide_error
  int           fail_count;
  int           pending;
  int           snd_idle;
  int           rcv_idle;

  fixed_point_vec3_alu_unit uut (.*);

  fpv_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  function automatic word_t fx(int v);
    return word_t'(longint'(v)) << FRAC_BITS;
  endfunction

  // mix of full-range, small fractional, mid-range and extreme values
  function automatic word_t rand_word();
    word_t w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       ;
      1, 2:    w = word_t'($signed(w[39:0]));
      3:       w = word_t'($signed(w[47:0]));
      default: begin
        case ($urandom_range(0, 4))
          0: w = FX_MAX;
          1: w = FX_MIN;
          2: w = '0;
          3: w = FX_ONE;
          default: w = -FX_ONE;
        endcase
      end
    endcase
    return w;
  endfunction

  task automatic send(op_t op, word_t ax, word_t ay, word_t az,
                      word_t bx, word_t by, word_t bz, word_t s);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {s, bz, by, bx, az, ay, ax};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_random();
    op_t   op;
    word_t a [3], b [3], s;
    op = op_t'($urandom_range(0, 23));
    for (int i = 0; i < 3; i++) begin
      a[i] = rand_word();
      b[i] = rand_word();
    end
    s = rand_word();
    if ($urandom_range(0, 9) == 0) b = a;
    if (op == OP_DIVS && $urandom_range(0, 5) == 0) s = '0;
    if ((op == OP_LERP_CLMP || op == OP_LERP) && $urandom_range(0, 1))
      s = word_t'($signed({$urandom_range(0, 7), $urandom}));
    send(op, a[0], a[1], a[2], b[0], b[1], b[2], s);
  endtask

  initial begin
    snd_idle   = 0;
    rcv_idle   = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = '0;
    in_tdata   = '0;
    out_tready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words: wrap, saturation and zero cases
    send(OP_ADD, FX_MAX, FX_MIN, fx(1), fx(1), FX_MIN, fx(-2), '0);
    send(OP_SUB, FX_MIN, FX_MAX, '0, fx(1), fx(-1), FX_MAX, '0);
    send(OP_NEG, FX_MIN, FX_MAX, fx(-5), '0, '0, '0, '0);
    send(OP_ABS, FX_MIN, fx(-7), fx(3), '0, '0, '0, '0);
    send(OP_SCALE, FX_MAX, FX_MIN, fx(-3), FX_MAX, FX_MIN, fx(2), '0);
    send(OP_MULS, fx(3), fx(-4), FX_MIN, '0, '0, '0, fx(-2));
    // zero divisor with positive, negative and zero components
    send(OP_DIVS, fx(5), fx(-5), '0, '0, '0, '0, '0);
    // quotient overflow
    send(OP_DIVS, FX_MAX, FX_MIN, fx(7), '0, '0, '0, 64'd1);
    send(OP_DIVS, fx(10), fx(-9), FX_MIN, '0, '0, '0, fx(-3));
    send(OP_ADDS, FX_MAX, fx(1), fx(-1), '0, '0, '0, fx(1));
    send(OP_SUBS, FX_MIN, fx(1), fx(-1), '0, '0, '0, fx(1));
    send(OP_DOT, fx(1), fx(2), fx(3), fx(4), fx(5), fx(6), '0);
    send(OP_CROSS, fx(1), '0, '0, '0, fx(1), '0, '0);
    // lerp fraction below zero, above one, unclamped above one
    send(OP_LERP_CLMP, fx(1), fx(2), fx(3), fx(9), fx(8), fx(7), fx(-1));
    send(OP_LERP_CLMP, fx(1), fx(2), fx(3), fx(9), fx(8), fx(7), fx(2));
    send(OP_LERP, fx(1), fx(2), fx(3), fx(9), fx(8), fx(7), fx(3));
    // sum of squares wraps around the 64-bit word
    send(OP_MAG, fx(40000), fx(40000), fx(40000), '0, '0, '0, '0);
    send(OP_SQMAG, fx(3), fx(4), fx(12), '0, '0, '0, '0);
    send(OP_DIST, fx(1), fx(2), fx(3), fx(4), fx(6), fx(3), '0);
    send(OP_NORM, '0, '0, '0, '0, '0, '0, '0);
    send(OP_NORM, fx(3), fx(4), '0, '0, '0, '0, '0);
    send(OP_EQUAL, FX_MIN, fx(2), FX_MAX, FX_MIN, fx(2), FX_MAX, fx(1));
    send(OP_XZ_DOT, fx(2), fx(9), fx(3), fx(4), fx(9), fx(5), '0);
    send(OP_XZ_CROSS, fx(2), '0, fx(3), fx(4), '0, fx(5), '0);
    send(OP_XZ_MAG, fx(3), fx(1), fx(4), '0, '0, '0, '0);
    send(OP_XZ_SQMAG, fx(-3), '0, FX_MAX, '0, '0, '0, '0);
    send(OP_XZ_DIST, fx(1), '0, fx(1), fx(4), '0, fx(5), '0);
    send(OP_XZ_SQDIST, FX_MIN, '0, FX_MAX, FX_MAX, '0, FX_MIN, '0);

    snd_idle = 25;
    rcv_idle = 82;
    repeat (650) send_random();
    snd_idle = 82;
    rcv_idle = 25;
    repeat (650) send_random();
    snd_idle = 0;
    rcv_idle = 0;
    repeat (650) send_random();
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
